// ===== design/udec_pkg.sv =====
package udec_pkg;

    localparam int TEXT_W      = 8;
    localparam int CP_W        = 21;
    localparam int LEN_W       = 3;
    localparam int WIN_DEPTH   = 4;
    localparam int WIN_IDX_W   = 2;
    localparam int CNT_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    typedef struct packed {
        logic [TEXT_W-1:0] data;
        logic [LEN_W-1:0]  lead_len;
        logic              is_cont;
        logic              last;
    } udec_item_t;

    typedef struct packed {
        logic [TEXT_W-1:0] data;
        logic [LEN_W-1:0]  lead_len;
        logic              is_cont;
    } udec_slot_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } udec_back_state_t;

    function automatic logic [LEN_W-1:0] lead_len_of(input logic [TEXT_W-1:0] b);
        logic [LEN_W-1:0] len;
        len = 3'd0;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

// ===== design/udec_front.sv =====
module udec_front
    import udec_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [TEXT_W-1:0] s_text_byte,
    input  logic              s_final_byte,
    output logic              q_valid,
    output udec_item_t        q_item,
    input  logic              q_pop
);

    localparam int PTR_W   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int COUNT_W = $clog2(QueueDepth + 1);

    udec_item_t         queue_mem [QueueDepth];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               push;
    logic               pop;
    udec_item_t         in_item;

    // classify each byte as it arrives
    always_comb begin
        in_item.data     = s_text_byte;
        in_item.lead_len = lead_len_of(s_text_byte);
        in_item.is_cont  = (s_text_byte[7:6] == 2'b10);
        in_item.last     = s_final_byte;
    end

    assign s_ready = (count_reg != COUNT_W'(QueueDepth));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_item  = queue_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== design/udec_back.sv =====
module udec_back
    import udec_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  udec_item_t      q_item,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_code_point,
    output logic            m_run_last,
    output logic            m_text_done
);

    udec_back_state_t  state_reg, state_next;
    udec_slot_t        win_reg [WIN_DEPTH];
    udec_slot_t        win_next [WIN_DEPTH];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              fin_reg, fin_next;
    logic              m_valid_reg, m_valid_next;
    logic [CP_W-1:0]   cp_reg, cp_next;
    logic              run_last_reg, run_last_next;
    logic              text_done_reg, text_done_next;

    logic [LEN_W-1:0]  len0;
    logic              seq_short;
    logic              bad_cont;
    logic              replace;
    logic [CNT_W-1:0]  step;
    logic [CNT_W-1:0]  cnt_after;
    logic [LEN_W-1:0]  next_len;
    logic              last_emit;
    logic              out_free;
    logic [CP_W-1:0]   cp_calc;
    logic [CNT_W-1:0]  src_idx [WIN_DEPTH];

    always_comb begin
        len0      = win_reg[0].lead_len;
        seq_short = (CNT_W'(len0) > cnt_reg);
        bad_cont  = ((len0 >= 3'd2) && !win_reg[1].is_cont)
                 || ((len0 >= 3'd3) && !win_reg[2].is_cont)
                 || ((len0 == 3'd4) && !win_reg[3].is_cont);
        replace   = (len0 == 3'd0) || bad_cont || seq_short;
        step      = ((len0 == 3'd0) || bad_cont) ? CNT_W'(1) : CNT_W'(len0);
        cnt_after = cnt_reg - step;
        next_len  = win_reg[step[WIN_IDX_W-1:0]].lead_len;
        // result is the last of this byte if nothing more can be emitted
        last_emit = seq_short || (cnt_after == '0)
                 || (!fin_reg && (CNT_W'(next_len) > cnt_after));
        out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        case (len0)
            3'd1: cp_calc = {13'd0, win_reg[0].data};
            3'd2: cp_calc = {10'd0, win_reg[0].data[4:0], win_reg[1].data[5:0]};
            3'd3: cp_calc = {5'd0, win_reg[0].data[3:0], win_reg[1].data[5:0],
                             win_reg[2].data[5:0]};
            3'd4: cp_calc = {win_reg[0].data[2:0], win_reg[1].data[5:0],
                             win_reg[2].data[5:0], win_reg[3].data[5:0]};
            default: cp_calc = REPLACEMENT_CP;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cp_next        = cp_reg;
        run_last_next  = run_last_reg;
        text_done_next = text_done_reg;
        q_pop          = 1'b0;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            src_idx[k] = CNT_W'(k) + step;
        end

        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop                                 = 1'b1;
                    win_next[cnt_reg[WIN_IDX_W-1:0]].data     = q_item.data;
                    win_next[cnt_reg[WIN_IDX_W-1:0]].lead_len = q_item.lead_len;
                    win_next[cnt_reg[WIN_IDX_W-1:0]].is_cont  = q_item.is_cont;
                    cnt_next                              = cnt_reg + 1'b1;
                    fin_next                              = q_item.last;
                    state_next                            = BK_RUN;
                end
            end
            BK_RUN: begin
                if (seq_short && !fin_reg) begin
                    // sequence still incomplete: keep bytes held
                    state_next = BK_IDLE;
                end else if (out_free) begin
                    m_valid_next   = 1'b1;
                    cp_next        = replace ? REPLACEMENT_CP : cp_calc;
                    run_last_next  = last_emit;
                    text_done_next = last_emit && fin_reg;
                    if (seq_short) begin
                        cnt_next = '0;
                    end else begin
                        for (int k = 0; k < WIN_DEPTH; k++) begin
                            if (src_idx[k] < CNT_W'(WIN_DEPTH)) begin
                                win_next[k] = win_reg[src_idx[k][WIN_IDX_W-1:0]];
                            end else begin
                                win_next[k] = '0;
                            end
                        end
                        cnt_next = cnt_after;
                    end
                    if (last_emit) begin
                        state_next = BK_IDLE;
                        if (fin_reg) begin
                            cnt_next = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            cnt_reg     <= '0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg       <= win_next;
        cp_reg        <= cp_next;
        run_last_reg  <= run_last_next;
        text_done_reg <= text_done_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_code_point = cp_reg;
    assign m_run_last   = run_last_reg;
    assign m_text_done  = text_done_reg;

endmodule

// ===== design/utf8_codepoint_decoder.sv =====
// channel   direction  payload                                   handshake
// s_        in         s_text_byte[7:0], s_final_byte            s_valid / s_ready
// m_        out        m_code_point[20:0], m_run_last, m_text_done  m_valid / m_ready
//
// bytes enter a small queue at up to one per cycle while it has room
// the decode side loads a byte in its idle state, then emits its code points from the run state,
// one per cycle while the output register is free, and returns to idle to load the next byte
// a byte that only extends a held sequence gives no transaction
// m_ stalls hold the output register and the decode side; the queue keeps taking bytes while it has room
// reset (aresetn low, synchronous) empties the queue and drops any held bytes
module utf8_codepoint_decoder
    import udec_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [TEXT_W-1:0] s_text_byte,
    input  logic              s_final_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CP_W-1:0]   m_code_point,
    output logic              m_run_last,
    output logic              m_text_done
);

    logic       q_valid;
    logic       q_pop;
    udec_item_t q_item;

    udec_front #(
        .QueueDepth (QueueDepth)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .s_final_byte (s_final_byte),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    udec_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_run_last   (m_run_last),
        .m_text_done  (m_text_done)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import udec_pkg::*;

    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM   = 320;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [TEXT_W-1:0] text;
        logic              fin;
        logic              typed;
        logic [CP_W-1:0]   cp;
    } stim_row_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            run_last;
        logic            text_done;
    } cp_result_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [TEXT_W-1:0] s_text_byte;
    logic              s_final_byte;
    logic              m_valid;
    logic              m_ready;
    logic [CP_W-1:0]   m_code_point;
    logic              m_run_last;
    logic              m_text_done;

    utf8_codepoint_decoder i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .s_final_byte (s_final_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_run_last   (m_run_last),
        .m_text_done  (m_text_done)
    );

    // directed text: typed rows give exactly one code point
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 21'h000000},
        '{8'h7F, 1'b0, 1'b1, 21'h00007F},
        '{8'h80, 1'b0, 1'b1, REPLACEMENT_CP},
        '{8'hFF, 1'b0, 1'b1, REPLACEMENT_CP},
        '{8'hC2, 1'b0, 1'b0, 21'h0},
        '{8'hA9, 1'b0, 1'b0, 21'h0},
        '{8'hED, 1'b0, 1'b0, 21'h0},
        '{8'hA0, 1'b0, 1'b0, 21'h0},
        '{8'h80, 1'b0, 1'b0, 21'h0},
        '{8'hF7, 1'b0, 1'b0, 21'h0},
        '{8'hBF, 1'b0, 1'b0, 21'h0},
        '{8'hBF, 1'b0, 1'b0, 21'h0},
        '{8'hBF, 1'b0, 1'b1, 21'h1FFFFF},
        '{8'hF0, 1'b0, 1'b0, 21'h0},
        '{8'h80, 1'b0, 1'b0, 21'h0},
        '{8'h80, 1'b0, 1'b0, 21'h0},
        '{8'h41, 1'b0, 1'b0, 21'h0},
        '{8'hE2, 1'b0, 1'b0, 21'h0},
        '{8'h41, 1'b0, 1'b0, 21'h0},
        '{8'h42, 1'b0, 1'b0, 21'h0},
        '{8'hE2, 1'b0, 1'b0, 21'h0},
        '{8'h82, 1'b1, 1'b1, REPLACEMENT_CP},
        '{8'h41, 1'b1, 1'b1, 21'h000041},
        '{8'hF0, 1'b1, 1'b1, REPLACEMENT_CP}
    };

    stim_row_t   random_text[$];
    cp_result_t  pending_code_points[$];
    cp_result_t  fresh_code_points[$];
    logic [7:0]  held_text [3];
    int unsigned held_len;
    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned texts_ended;
    int unsigned cps_checked;
    int unsigned quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic int unsigned seq_len(input logic [7:0] b, output logic [CP_W-1:0] bits);
        int unsigned len;
        bits = '0;
        len = 0;
        if (b[7] == 1'b0) begin
            bits = CP_W'(b[6:0]);
            len = 1;
        end else if (b[7:5] == 3'b110) begin
            bits = CP_W'(b[4:0]);
            len = 2;
        end else if (b[7:4] == 4'b1110) begin
            bits = CP_W'(b[3:0]);
            len = 3;
        end else if (b[7:3] == 5'b11110) begin
            bits = CP_W'(b[2:0]);
            len = 4;
        end
        return len;
    endfunction

    function automatic void add_fresh(input logic [CP_W-1:0] cp);
        fresh_code_points.insert(fresh_code_points.size(), cp_result_t'{cp, 1'b0, 1'b0});
    endfunction

    // code points completed by one byte, left in fresh_code_points
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic [7:0]      win [4];
        logic [CP_W-1:0] cp;
        int unsigned     m, i, k, len;
        logic            good;
        fresh_code_points.delete();
        for (k = 0; k < held_len; k++) begin
            win[k] = held_text[k];
        end
        win[held_len] = b;
        m = held_len + 1;
        held_len = 0;
        held_text = '{default: 8'h00};
        i = 0;
        while (i < m) begin
            len = seq_len(win[i], cp);
            if (len == 0) begin
                add_fresh(REPLACEMENT_CP);
                i++;
            end else if (i + len > m) begin
                if (fin) begin
                    add_fresh(REPLACEMENT_CP);
                end else begin
                    for (k = 0; i + k < m; k++) begin
                        held_text[k] = win[i + k];
                    end
                    held_len = m - i;
                end
                i = m;
            end else begin
                good = 1'b1;
                for (k = 1; k < len; k++) begin
                    good &= (win[i + k][7:6] == 2'b10);
                    cp = {cp[CP_W-7:0], win[i + k][5:0]};
                end
                if (good) begin
                    add_fresh(cp);
                    i += len;
                end else begin
                    add_fresh(REPLACEMENT_CP);
                    i++;
                end
            end
        end
        if (fresh_code_points.size() != 0) begin
            fresh_code_points[$].run_last = 1'b1;
            fresh_code_points[$].text_done = fin;
        end
    endfunction

    function automatic void push_text(input logic [7:0] b);
        random_text.insert(random_text.size(),
                           stim_row_t'{b, ($urandom_range(0, 15) == 0), 1'b0, 21'h0});
    endfunction

    // mostly well-formed sequences, some cut short, some noise
    task automatic build_random_text(input int unsigned n_items);
        int unsigned pick, len, keep, k;
        logic [7:0]  lead;
        while (random_text.size() < n_items) begin
            pick = $urandom_range(0, 99);
            len = $urandom_range(1, 4);
            if (pick < 20) begin
                push_text(8'($urandom));
            end else begin
                case (len)
                    1: lead = {1'b0, 7'($urandom)};
                    2: lead = {3'b110, 5'($urandom)};
                    3: lead = {4'b1110, 4'($urandom)};
                    default: lead = {5'b11110, 3'($urandom)};
                endcase
                push_text(lead);
                keep = (pick < 35) ? $urandom_range(0, len - 1) : len - 1;
                for (k = 0; k < keep; k++) begin
                    push_text({2'b10, 6'($urandom)});
                end
            end
        end
        random_text[$].fin = 1'b1;
    endtask

    task automatic send_byte(input stim_row_t row);
        int unsigned gap;
        gap = ((bytes_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_text_byte  <= row.text;
        s_final_byte <= row.fin;
        do @(posedge aclk); while (!s_ready);
        decode_byte(row.text, row.fin);
        if (row.typed) begin
            pending_code_points.insert(pending_code_points.size(),
                                       cp_result_t'{row.cp, 1'b1, row.fin});
        end else begin
            foreach (fresh_code_points[k]) begin
                pending_code_points.insert(pending_code_points.size(), fresh_code_points[k]);
            end
        end
        bytes_sent++;
        if (row.fin) begin
            texts_ended++;
        end
    endtask

    initial begin
        int unsigned gap;
        cp_result_t  want;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = ((cps_checked / 30) % 3 == 1) ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            cps_checked++;
            if (pending_code_points.size() == 0) begin
                note_mismatch($sformatf("unexpected code point %h", m_code_point));
            end else begin
                want = pending_code_points.pop_front();
                if (m_code_point !== want.code_point) begin
                    note_mismatch($sformatf("code_point %h, want %h",
                                            m_code_point, want.code_point));
                end
                if (m_run_last !== want.run_last) begin
                    note_mismatch($sformatf("run_last %b, want %b (cp %h)",
                                            m_run_last, want.run_last, want.code_point));
                end
                if (m_text_done !== want.text_done) begin
                    note_mismatch($sformatf("text_done %b, want %b (cp %h)",
                                            m_text_done, want.text_done, want.code_point));
                end
            end
        end
    end

    // no transaction on either side for too long
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: %0d cycles without a transaction, %0d code points owed",
                         quiet_cycles, pending_code_points.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        mismatches   = 0;
        bytes_sent   = 0;
        texts_ended  = 0;
        cps_checked  = 0;
        held_len     = 0;
        held_text    = '{default: 8'h00};
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_text_byte  <= '0;
        s_final_byte <= 1'b0;
        build_random_text(N_RANDOM);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r]);
        end

        foreach (random_text[r]) begin
            send_byte(random_text[r]);
            if (r == N_RANDOM / 2) begin
                // hold the sender off until the output side has caught up
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_code_points.size() != 0);
            end
        end
        s_valid <= 1'b0;

        while (pending_code_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d text bytes over %0d texts, directed and random",
                 bytes_sent, texts_ended);
        $display("checked %0d code points, %0d mismatches", cps_checked, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
